// ===== sv/hgmg_pkg.sv =====
package hgmg_pkg;

  localparam int SIDE_W   = 9;
  localparam int MAX_SIDE = 256;
  localparam int IDX_W    = 17;
  localparam int RATIO_W  = 17;
  localparam int CIDX_W   = 4;
  localparam int QDEPTH   = 2;
  localparam logic [RATIO_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CIDX_W-1:0] {
    REG_ROWS     = 4'd0,
    REG_COLS     = 4'd1,
    REG_MIN_X    = 4'd2,
    REG_MAX_X    = 4'd3,
    REG_MIN_Z    = 4'd4,
    REG_MAX_Z    = 4'd5,
    REG_TEX_MIN  = 4'd6,
    REG_TEX_MAX  = 4'd7
  } reg_idx_t;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_CELL   = 1'b1
  } kind_t;

  typedef struct packed {
    logic [SIDE_W-1:0] rows;
    logic [SIDE_W-1:0] cols;
    logic [31:0]       min_x;
    logic [31:0]       max_x;
    logic [31:0]       min_z;
    logic [31:0]       max_z;
    logic [63:0]       tex_min;
    logic [63:0]       tex_max;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic [31:0]       height;
    logic [31:0]       min_h;
    logic [31:0]       max_h;
    logic [IDX_W-1:0]  idx_top;
    logic [IDX_W-1:0]  idx_bot;
  } cmd_t;

  typedef struct packed {
    logic              push;
    logic              full;
  } qctl_t;

endpackage

// ===== sv/hgmg_if.sv =====
interface hgmg_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] height;
  modport source (output valid, kind, height, input ready);
  modport sink   (input valid, kind, height, output ready);
endinterface

interface hgmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_height;
  logic signed [31:0] vertex_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic [16:0]        alpha_u;
  logic [16:0]        alpha_v;
  logic [16:0]        index_value;
  logic signed [31:0] height_lo;
  logic signed [31:0] height_hi;
  logic               last;
  modport source (output valid, vertex_x, vertex_height, vertex_z, tex_u, tex_v, alpha_u,
                  alpha_v, index_value, height_lo, height_hi, last, input ready);
  modport sink   (input valid, vertex_x, vertex_height, vertex_z, tex_u, tex_v, alpha_u,
                  alpha_v, index_value, height_lo, height_hi, last, output ready);
endinterface

// ===== sv/hgmg_queue.sv =====
module hgmg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  hgmg_pkg::qctl_t ctl_in,
  input  hgmg_pkg::cmd_t  wr_cmd,
  input  logic            pop,
  output logic            empty,
  output logic            full,
  output hgmg_pkg::cmd_t  rd_cmd
);
  localparam int PW = $clog2(hgmg_pkg::QDEPTH);

  hgmg_pkg::cmd_t          mem_r [hgmg_pkg::QDEPTH];
  logic [PW-1:0]           wr_ptr_r, rd_ptr_r;
  logic [PW:0]             count_r;
  logic                    do_push, do_pop;

  assign full    = (count_r == (PW+1)'(hgmg_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = ctl_in.push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(hgmg_pkg::QDEPTH)) else $error("queue count overflow");
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_in.push |-> !full) else $error("push into full queue");
endmodule

// ===== sv/hgmg_front.sv =====
module hgmg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  hgmg_pkg::cfg_t      cfg,
  input  logic                restart,
  hgmg_in_if.sink             in_ch,
  input  logic                q_full,
  output hgmg_pkg::qctl_t     q_ctl,
  output hgmg_pkg::cmd_t      cmd
);
  localparam int SW = hgmg_pkg::SIDE_W;

  logic [SW-1:0]  vcol_r, vrow_r, ccol_r, crow_r;
  logic [31:0]    low_r, high_r;
  logic           seen_r;
  logic           acc;
  logic [31:0]    low_nxt, high_nxt;
  logic [SW:0]    stride;
  logic [2*SW:0]  prod;
  logic [hgmg_pkg::IDX_W-1:0] top;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (!seen_r) begin
      low_nxt  = in_ch.height;
      high_nxt = in_ch.height;
    end else begin
      if ($signed(in_ch.height) < $signed(low_r))  low_nxt  = in_ch.height;
      if ($signed(in_ch.height) > $signed(high_r)) high_nxt = in_ch.height;
    end
  end

  assign stride = {1'b0, cfg.cols} + 1'b1;
  assign prod   = crow_r * stride;
  assign top    = hgmg_pkg::IDX_W'(prod) + hgmg_pkg::IDX_W'(ccol_r);

  always_comb begin
    cmd.kind    = hgmg_pkg::kind_t'(in_ch.kind);
    cmd.col     = vcol_r;
    cmd.row     = vrow_r;
    cmd.height  = in_ch.height;
    cmd.idx_top = top;
    cmd.idx_bot = top + hgmg_pkg::IDX_W'(stride);
    if (in_ch.kind == hgmg_pkg::KIND_VERTEX) begin
      cmd.min_h = low_nxt;
      cmd.max_h = high_nxt;
    end else begin
      cmd.min_h = seen_r ? low_r  : '0;
      cmd.max_h = seen_r ? high_r : '0;
    end
  end

  assign q_ctl.push = acc;
  assign q_ctl.full = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcol_r <= '0;
      vrow_r <= '0;
      ccol_r <= '0;
      crow_r <= '0;
      low_r  <= '0;
      high_r <= '0;
      seen_r <= 1'b0;
    end else if (restart) begin
      vcol_r <= '0;
      vrow_r <= '0;
      ccol_r <= '0;
      crow_r <= '0;
      seen_r <= 1'b0;
    end else if (acc) begin
      if (in_ch.kind == hgmg_pkg::KIND_VERTEX) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
        seen_r <= !((vcol_r >= cfg.cols) && (vrow_r >= cfg.rows));
        if (vcol_r >= cfg.cols) begin
          vcol_r <= '0;
          if (vrow_r >= cfg.rows) begin
            vrow_r <= '0;
          end else begin
            vrow_r <= vrow_r + 1'b1;
          end
        end else begin
          vcol_r <= vcol_r + 1'b1;
        end
      end else begin
        if ({1'b0, ccol_r} + 1'b1 >= {1'b0, cfg.cols}) begin
          ccol_r <= '0;
          if ({1'b0, crow_r} + 1'b1 >= {1'b0, cfg.rows}) crow_r <= '0;
          else crow_r <= crow_r + 1'b1;
        end else begin
          ccol_r <= ccol_r + 1'b1;
        end
      end
    end
  end

  a_vcol_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcol_r <= cfg.cols) else $error("vertex column out of range");
endmodule

// ===== sv/hgmg_back.sv =====
module hgmg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  hgmg_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  hgmg_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  hgmg_out_if.source      out_ch
);
  localparam int SW = hgmg_pkg::SIDE_W;
  localparam int RW = hgmg_pkg::RATIO_W;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL, ST_OUT, ST_EMIT} state_t;

  state_t               state_r;
  hgmg_pkg::cmd_t       cmd_r;
  logic [4:0]           dcnt_r;
  logic [2:0]           step_r;
  logic [SW-1:0]        remx_r, remz_r;
  logic [RW-1:0]        dvdx_r, dvdz_r, qx_r, qz_r;
  logic signed [50:0]   prod_r;
  logic signed [31:0]   lo_r;
  logic [31:0]          res_r [4];
  logic                 slot_free;
  logic                 load;

  logic [SW:0]          tx, tz;
  logic                 bx, bz;
  logic signed [31:0]   lo_sel, hi_sel;
  logic [RW-1:0]        ratio_sel;
  logic signed [32:0]   span;
  logic signed [35:0]   sum;
  logic [31:0]          sat;

  logic                 ov_r;
  logic signed [31:0]   o_x_r, o_h_r, o_z_r, o_u_r, o_v_r, o_min_r, o_max_r;
  logic [RW-1:0]        o_au_r, o_av_r;
  logic [hgmg_pkg::IDX_W-1:0] o_idx_r;
  logic                 o_last_r;

  assign slot_free = !ov_r || out_ch.ready;
  assign load      = slot_free && (state_r == ST_OUT || state_r == ST_EMIT);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  assign tx = {remx_r, dvdx_r[RW-1]};
  assign tz = {remz_r, dvdz_r[RW-1]};
  assign bx = tx >= {1'b0, cfg.cols};
  assign bz = tz >= {1'b0, cfg.rows};

  always_comb begin
    unique case (step_r[1:0])
      2'd0: begin
        lo_sel = cfg.min_x; hi_sel = cfg.max_x; ratio_sel = qx_r;
      end
      2'd1: begin
        lo_sel = cfg.min_z; hi_sel = cfg.max_z; ratio_sel = qz_r;
      end
      2'd2: begin
        lo_sel = cfg.tex_min[63:32]; hi_sel = cfg.tex_max[63:32]; ratio_sel = qx_r;
      end
      default: begin
        lo_sel = cfg.tex_min[31:0]; hi_sel = cfg.tex_max[31:0];
        ratio_sel = hgmg_pkg::ONE_Q16 - qz_r;
      end
    endcase
  end

  assign span = 33'(hi_sel) - 33'(lo_sel);
  assign sum  = 36'(lo_r) + 36'(prod_r >>> 16);

  always_comb begin
    if (sum > 36'sd2147483647)        sat = 32'h7fff_ffff;
    else if (sum < -36'sd2147483648)  sat = 32'h8000_0000;
    else                              sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      dcnt_r  <= '0;
      step_r  <= '0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd_r  <= q_cmd;
            remx_r <= q_cmd.col >> 1;
            remz_r <= q_cmd.row >> 1;
            dvdx_r <= {q_cmd.col[0], (RW-1)'(0)};
            dvdz_r <= {q_cmd.row[0], (RW-1)'(0)};
            dcnt_r <= '0;
            step_r <= '0;
            state_r <= (q_cmd.kind == hgmg_pkg::KIND_VERTEX) ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          remx_r <= bx ? SW'(tx - {1'b0, cfg.cols}) : SW'(tx);
          remz_r <= bz ? SW'(tz - {1'b0, cfg.rows}) : SW'(tz);
          qx_r   <= {qx_r[RW-2:0], bx};
          qz_r   <= {qz_r[RW-2:0], bz};
          dvdx_r <= dvdx_r << 1;
          dvdz_r <= dvdz_r << 1;
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'(RW-1)) state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= span * $signed({1'b0, ratio_sel});
          lo_r   <= lo_sel;
          if (step_r != '0) res_r[step_r[1:0] - 2'd1] <= sat;
          step_r <= step_r + 1'b1;
          if (step_r == 3'd4) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) begin
            o_x_r    <= res_r[0];
            o_z_r    <= res_r[1];
            o_u_r    <= res_r[2];
            o_v_r    <= res_r[3];
            o_h_r    <= cmd_r.height;
            o_au_r   <= qx_r;
            o_av_r   <= hgmg_pkg::ONE_Q16 - qz_r;
            o_idx_r  <= '0;
            o_min_r  <= cmd_r.min_h;
            o_max_r  <= cmd_r.max_h;
            o_last_r <= 1'b1;
            state_r  <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            o_x_r    <= '0;
            o_z_r    <= '0;
            o_u_r    <= '0;
            o_v_r    <= '0;
            o_h_r    <= '0;
            o_au_r   <= '0;
            o_av_r   <= '0;
            o_min_r  <= cmd_r.min_h;
            o_max_r  <= cmd_r.max_h;
            o_last_r <= (step_r == 3'd5);
            unique case (step_r)
              3'd0, 3'd3: o_idx_r <= cmd_r.idx_top;
              3'd1:       o_idx_r <= cmd_r.idx_bot;
              3'd2, 3'd4: o_idx_r <= cmd_r.idx_bot + 1'b1;
              default:    o_idx_r <= cmd_r.idx_top + 1'b1;
            endcase
            step_r <= step_r + 1'b1;
            if (step_r == 3'd5) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.vertex_x      = o_x_r;
  assign out_ch.vertex_height = o_h_r;
  assign out_ch.vertex_z      = o_z_r;
  assign out_ch.tex_u         = o_u_r;
  assign out_ch.tex_v         = o_v_r;
  assign out_ch.alpha_u       = o_au_r;
  assign out_ch.alpha_v       = o_av_r;
  assign out_ch.index_value   = o_idx_r;
  assign out_ch.height_lo     = o_min_r;
  assign out_ch.height_hi     = o_max_r;
  assign out_ch.last          = o_last_r;

  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> (qx_r <= hgmg_pkg::ONE_Q16) && (qz_r <= hgmg_pkg::ONE_Q16))
    else $error("ratio above one");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != ST_IDLE) else $error("pop without start");
  a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> step_r <= 3'd5) else $error("emit step overrun");
endmodule

// ===== sv/heightfield_grid_mesh_generator.sv =====
// Terrain grid mesh generator.
// in_ch: one item per transfer; kind 0 carries a height sample of the next
//   vertex in row-major order, kind 1 requests the six indices of the next cell.
// out_ch: one result per vertex item, six per cell item; last marks the final one.
// cfg_*: register write port, index 0..7 (rows, cols, x/z corners, tex corners);
//   indexes above 7 are dropped. Writing rows or cols restarts the grid.
// A front stage tracks counters and min/max height and pushes a command into a
// two-entry queue; a back stage computes and holds results in an output register.
// Vertex path: the column and row ratios come from a
//   restoring divider at one quotient bit per cycle, then one shared
//   33x18 multiplier does the four interpolations. The back stage finishes one
//   command before it pops the next; a cell item puts six results on the port.
// Reset clears the registers to a unit square and the grid counters to zero.
// While out_ch is stalled the held result stays; the queue keeps accepting
// until two commands wait.
module heightfield_grid_mesh_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  hgmg_in_if.sink                       in_ch,
  hgmg_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [hgmg_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [63:0]                   cfg_data
);
  localparam int SW = hgmg_pkg::SIDE_W;

  hgmg_pkg::cfg_t  cfg_r;
  hgmg_pkg::cmd_t  wr_cmd, rd_cmd;
  hgmg_pkg::qctl_t q_ctl;
  logic            q_empty, q_full, q_pop, restart;
  logic [SW-1:0]   side;

  always_comb begin
    if (cfg_data[SW-1:0] == '0)                           side = SW'(1);
    else if (int'(cfg_data[SW-1:0]) > hgmg_pkg::MAX_SIDE) side = SW'(hgmg_pkg::MAX_SIDE);
    else                                                  side = cfg_data[SW-1:0];
  end

  assign restart = cfg_we && (cfg_index == hgmg_pkg::REG_ROWS ||
                              cfg_index == hgmg_pkg::REG_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows     <= SW'(1);
      cfg_r.cols     <= SW'(1);
      cfg_r.min_x    <= '0;
      cfg_r.max_x    <= 32'h0001_0000;
      cfg_r.min_z    <= '0;
      cfg_r.max_z    <= 32'h0001_0000;
      cfg_r.tex_min  <= '0;
      cfg_r.tex_max  <= 64'h0001_0000_0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hgmg_pkg::REG_ROWS:     cfg_r.rows     <= side;
        hgmg_pkg::REG_COLS:     cfg_r.cols     <= side;
        hgmg_pkg::REG_MIN_X:    cfg_r.min_x    <= cfg_data[31:0];
        hgmg_pkg::REG_MAX_X:    cfg_r.max_x    <= cfg_data[31:0];
        hgmg_pkg::REG_MIN_Z:    cfg_r.min_z    <= cfg_data[31:0];
        hgmg_pkg::REG_MAX_Z:    cfg_r.max_z    <= cfg_data[31:0];
        hgmg_pkg::REG_TEX_MIN:  cfg_r.tex_min  <= cfg_data;
        hgmg_pkg::REG_TEX_MAX:  cfg_r.tex_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  hgmg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .restart (restart),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_ctl   (q_ctl),
    .cmd     (wr_cmd)
  );

  hgmg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (q_ctl),
    .wr_cmd  (wr_cmd),
    .pop     (q_pop),
    .empty   (q_empty),
    .full    (q_full),
    .rd_cmd  (rd_cmd)
  );

  hgmg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_cmd   (rd_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

// ===== tb/tb_heightfield_grid_mesh_generator.sv =====
module tb_heightfield_grid_mesh_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX      = hgmg_pkg::MAX_SIDE;
  localparam int SETTLE_CYCLES = 60;
  localparam int FIRST_UNUSED  = 8;
  localparam int NUM_PHASES    = 10;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef struct {
    logic signed [31:0] x, h, z, u, v;
    logic [16:0]        au, av, idx;
    logic signed [31:0] mn, mx;
    logic               last;
  } mesh_res_t;

  typedef struct {
    hgmg_pkg::kind_t kind;
    logic [31:0] h;
    bit          lit;
    logic [31:0] x, z, u, v;
    logic [16:0] au, av;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hgmg_pkg::CIDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  hgmg_in_if  in_ch ();
  hgmg_out_if out_ch ();

  heightfield_grid_mesh_generator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block
  int unsigned m_rows, m_cols;
  logic [31:0] m_min_x, m_max_x, m_min_z, m_max_z;
  logic [63:0] m_tex_min, m_tex_max;
  int unsigned v_col, v_row, t_col, t_row;
  logic [31:0] low_h, high_h;
  bit          h_seen;

  mesh_res_t mesh_exp_q[$];
  int errors = 0;
  int idle_in = 0;
  int idle_out = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[heightfield_grid_mesh_generator] ERROR");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] lerp_q16(logic [31:0] lo_b, logic [31:0] hi_b,
                                           logic [16:0] r);
    longint lo, span, p;
    lo   = longint'($signed(lo_b));
    span = longint'($signed(hi_b)) - lo;
    p    = span * longint'(r);
    p    = (p >>> 16) + lo;
    if (p > longint'($signed(S_MAX))) p = longint'($signed(S_MAX));
    if (p < longint'($signed(S_MIN))) p = longint'($signed(S_MIN));
    return p[31:0];
  endfunction

  function automatic int unsigned clamp_side(logic [63:0] d);
    int unsigned s;
    s = d[8:0];
    if (s == 0) return 1;
    if (s > SIDE_MAX) return SIDE_MAX;
    return s;
  endfunction

  task automatic restart_grid();
    v_col = 0; v_row = 0; t_col = 0; t_row = 0; h_seen = 0;
  endtask

  task automatic model_reset();
    m_rows = 1; m_cols = 1;
    m_min_x = 0; m_max_x = Q_ONE; m_min_z = 0; m_max_z = Q_ONE;
    m_tex_min = 0; m_tex_max = {Q_ONE, Q_ONE};
    low_h = 0; high_h = 0;
    restart_grid();
  endtask

  task automatic model_cfg(input logic [hgmg_pkg::CIDX_W-1:0] idx, input logic [63:0] d);
    case (idx)
      hgmg_pkg::REG_ROWS:    begin m_rows = clamp_side(d); restart_grid(); end
      hgmg_pkg::REG_COLS:    begin m_cols = clamp_side(d); restart_grid(); end
      hgmg_pkg::REG_MIN_X:   m_min_x = d[31:0];
      hgmg_pkg::REG_MAX_X:   m_max_x = d[31:0];
      hgmg_pkg::REG_MIN_Z:   m_min_z = d[31:0];
      hgmg_pkg::REG_MAX_Z:   m_max_z = d[31:0];
      hgmg_pkg::REG_TEX_MIN: m_tex_min = d;
      hgmg_pkg::REG_TEX_MAX: m_tex_max = d;
      default: ;
    endcase
  endtask

  task automatic predict_mesh_item(input hgmg_pkg::kind_t k, input logic [31:0] h);
    mesh_res_t r;
    logic [16:0] rx, rz, rzi;
    int unsigned stride, top, bot;
    int unsigned ids[6];
    if (k == hgmg_pkg::KIND_VERTEX) begin
      rx  = 17'((longint'(v_col) * 65536) / m_cols);
      rz  = 17'((longint'(v_row) * 65536) / m_rows);
      rzi = hgmg_pkg::ONE_Q16 - rz;
      if (!h_seen) begin
        low_h = h; high_h = h; h_seen = 1;
      end else begin
        if ($signed(h) < $signed(low_h)) low_h = h;
        if ($signed(h) > $signed(high_h)) high_h = h;
      end
      r.x = lerp_q16(m_min_x, m_max_x, rx);
      r.h = h;
      r.z = lerp_q16(m_min_z, m_max_z, rz);
      r.u = lerp_q16(m_tex_min[63:32], m_tex_max[63:32], rx);
      r.v = lerp_q16(m_tex_min[31:0], m_tex_max[31:0], rzi);
      r.au = rx; r.av = rzi; r.idx = 0;
      r.mn = low_h; r.mx = high_h; r.last = 1;
      mesh_exp_q.push_back(r);
      if (v_col >= m_cols) begin
        v_col = 0;
        if (v_row >= m_rows) begin
          v_row = 0; h_seen = 0;
        end else v_row++;
      end else v_col++;
    end else begin
      stride = m_cols + 1;
      top = t_row * stride + t_col;
      bot = (t_row + 1) * stride + t_col;
      ids = '{top, bot, bot + 1, top, bot + 1, top + 1};
      for (int i = 0; i < 6; i++) begin
        r.x = 0; r.h = 0; r.z = 0; r.u = 0; r.v = 0; r.au = 0; r.av = 0;
        r.idx = 17'(ids[i]);
        r.mn = h_seen ? low_h : 0;
        r.mx = h_seen ? high_h : 0;
        r.last = (i == 5);
        mesh_exp_q.push_back(r);
      end
      if (t_col + 1 >= m_cols) begin
        t_col = 0;
        if (t_row + 1 >= m_rows) t_row = 0;
        else t_row++;
      end else t_col++;
    end
  endtask

  task automatic send_item(input hgmg_pkg::kind_t k, input logic [31:0] h);
    while ($urandom_range(99) < idle_in) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid  <= 1;
    in_ch.kind   <= k;
    in_ch.height <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_mesh_item(k, h);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (mesh_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [hgmg_pkg::CIDX_W-1:0] idx, input logic [63:0] d);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    model_cfg(idx, d);
  endtask

  function automatic logic [31:0] rand_corner();
    case ($urandom_range(5))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_height();
    case ($urandom_range(7))
      0: return S_MIN;
      1: return S_MAX;
      2: return 0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= idle_out);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mesh_exp_q.size() == 0) begin
        report("unexpected result transfer");
      end else begin
        mesh_res_t e;
        e = mesh_exp_q.pop_front();
        if (out_ch.vertex_x !== e.x)
          report($sformatf("vertex_x %h exp %h", out_ch.vertex_x, e.x));
        if (out_ch.vertex_height !== e.h)
          report($sformatf("vertex_height %h exp %h", out_ch.vertex_height, e.h));
        if (out_ch.vertex_z !== e.z)
          report($sformatf("vertex_z %h exp %h", out_ch.vertex_z, e.z));
        if (out_ch.tex_u !== e.u)
          report($sformatf("tex_u %h exp %h", out_ch.tex_u, e.u));
        if (out_ch.tex_v !== e.v)
          report($sformatf("tex_v %h exp %h", out_ch.tex_v, e.v));
        if (out_ch.alpha_u !== e.au)
          report($sformatf("alpha_u %h exp %h", out_ch.alpha_u, e.au));
        if (out_ch.alpha_v !== e.av)
          report($sformatf("alpha_v %h exp %h", out_ch.alpha_v, e.av));
        if (out_ch.index_value !== e.idx)
          report($sformatf("index_value %0d exp %0d", out_ch.index_value, e.idx));
        if (out_ch.height_lo !== e.mn)
          report($sformatf("height_lo %h exp %h", out_ch.height_lo, e.mn));
        if (out_ch.height_hi !== e.mx)
          report($sformatf("height_hi %h exp %h", out_ch.height_hi, e.mx));
        if (out_ch.last !== e.last)
          report($sformatf("last %b exp %b", out_ch.last, e.last));
      end
    end
  end

  initial begin
    dir_row_t dir_tbl[8];
    logic [63:0] sizes[2];
    int n_items;
    in_ch.valid = 0;
    in_ch.kind = hgmg_pkg::KIND_VERTEX;
    in_ch.height = 0;
    cfg_we = 0;
    cfg_index = hgmg_pkg::REG_ROWS;
    cfg_data = 0;
    rst_n = 0;
    model_reset();

    // reset grid is the 1x1 unit square
    dir_tbl[0] = '{hgmg_pkg::KIND_VERTEX, S_MAX, 1, 0, 0, 0, Q_ONE, 0, hgmg_pkg::ONE_Q16};
    dir_tbl[1] = '{hgmg_pkg::KIND_VERTEX, S_MIN, 1, Q_ONE, 0, Q_ONE, Q_ONE,
                   hgmg_pkg::ONE_Q16, hgmg_pkg::ONE_Q16};
    dir_tbl[2] = '{hgmg_pkg::KIND_VERTEX, 32'h0, 1, 0, Q_ONE, 0, 0, 0, 0};
    dir_tbl[3] = '{hgmg_pkg::KIND_VERTEX, 32'hFFFF_FFFF, 1, Q_ONE, Q_ONE, Q_ONE, 0,
                   hgmg_pkg::ONE_Q16, 0};
    dir_tbl[4] = '{hgmg_pkg::KIND_CELL,   32'h0,         0, 0, 0, 0, 0, 0, 0};
    dir_tbl[5] = '{hgmg_pkg::KIND_CELL,   32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0};
    dir_tbl[6] = '{hgmg_pkg::KIND_VERTEX, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0};
    dir_tbl[7] = '{hgmg_pkg::KIND_CELL,   32'h0,         0, 0, 0, 0, 0, 0, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int mode = 0; mode < 3; mode++) begin
      idle_in  = (mode == 0) ? 18 : (mode == 1) ? 76 : 0;
      idle_out = (mode == 0) ? 76 : (mode == 1) ? 18 : 0;
      if (mode == 0) begin
        foreach (dir_tbl[i]) begin
          send_item(dir_tbl[i].kind, dir_tbl[i].h);
          if (dir_tbl[i].lit) begin
            mesh_exp_q[$].x  = dir_tbl[i].x;
            mesh_exp_q[$].z  = dir_tbl[i].z;
            mesh_exp_q[$].u  = dir_tbl[i].u;
            mesh_exp_q[$].v  = dir_tbl[i].v;
            mesh_exp_q[$].au = dir_tbl[i].au;
            mesh_exp_q[$].av = dir_tbl[i].av;
          end
        end
        drain();
      end
      for (int ph = 0; ph < NUM_PHASES / 3 + 1; ph++) begin
        case ((mode * 4 + ph) % 4)
          0: begin sizes[0] = 0;      sizes[1] = 64'h1FF; end
          1: begin sizes[0] = 64'h100; sizes[1] = 0;     end
          default: begin
            sizes[0] = $urandom_range(1, 4);
            sizes[1] = $urandom_range(1, 4);
          end
        endcase
        cfg_write(hgmg_pkg::REG_ROWS, sizes[0]);
        cfg_write(hgmg_pkg::REG_COLS, sizes[1]);
        cfg_write(hgmg_pkg::REG_MIN_X, {$urandom, rand_corner()});
        cfg_write(hgmg_pkg::REG_MAX_X, {$urandom, rand_corner()});
        cfg_write(hgmg_pkg::REG_MIN_Z, {$urandom, rand_corner()});
        cfg_write(hgmg_pkg::REG_MAX_Z, {$urandom, rand_corner()});
        cfg_write(hgmg_pkg::REG_TEX_MIN, {rand_corner(), rand_corner()});
        cfg_write(hgmg_pkg::REG_TEX_MAX, {rand_corner(), rand_corner()});
        cfg_write(hgmg_pkg::CIDX_W'($urandom_range(FIRST_UNUSED, 15)), {$urandom, $urandom});
        cfg_we <= 0;
        @(posedge clk);
        n_items = $urandom_range(14, 22);
        for (int i = 0; i < n_items; i++) begin
          if ($urandom_range(99) < 25) send_item(hgmg_pkg::KIND_CELL, $urandom);
          else send_item(hgmg_pkg::KIND_VERTEX, rand_height());
        end
        drain();
      end
    end

    if (errors == 0) begin
      $display("[heightfield_grid_mesh_generator] OK");
    end else begin
      $display("[heightfield_grid_mesh_generator] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/hgmg_pkg.sv
sv/hgmg_if.sv
sv/hgmg_queue.sv
sv/hgmg_front.sv
sv/hgmg_back.sv
sv/heightfield_grid_mesh_generator.sv
tb/tb_heightfield_grid_mesh_generator.sv
